>>> hw/rtl/mcbrb_pkg.sv
package mcbrb_pkg;

  localparam int CHANNELS    = 4;
  localparam int MAX_DEPTH   = 256;
  localparam int NUM_REGS    = 4;
  localparam int CH_W        = 2;
  localparam int DATA_W      = 8;
  localparam int SIZE_W      = 9;
  localparam int REG_IDX_W   = 2;
  localparam int PTR_W       = $clog2(MAX_DEPTH);
  localparam int CAP_W       = $clog2(MAX_DEPTH + 1);
  localparam int WIDE_W      = CAP_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_QUERY,
    OP_CLEAR,
    OP_REJECT,
    OP_NOCHAN
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CH_W-1:0]   ch;
    logic [DATA_W-1:0] data;
    logic [CAP_W-1:0]  cap;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hw/rtl/mcbrb_if.sv
interface mcbrb_in_if
  import mcbrb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [CH_W-1:0]   channel;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, output mode, output channel, output data_in, input ready);
  modport sink (input valid, input mode, input channel, input data_in, output ready);
endinterface

interface mcbrb_out_if
  import mcbrb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              status;
  logic [DATA_W-1:0] data_out;
  logic [CAP_W-1:0]  free_count;
  logic              is_empty;

  modport source (output valid, output status, output data_out, output free_count,
                  output is_empty, input ready);
  modport sink (input valid, input status, input data_out, input free_count,
                input is_empty, output ready);
endinterface

>>> hw/rtl/mcbrb_front.sv
module mcbrb_front
  import mcbrb_pkg::*;
(
  mcbrb_in_if.sink         in_i,
  input  logic [SIZE_W-1:0] size_i [NUM_REGS],
  input  q_status_t         q_status_i,
  output logic              push_o,
  output cmd_t              push_cmd_o
);

  logic             chan_ok;
  logic [SIZE_W-1:0] size_sel;
  logic [CAP_W-1:0] cap;

  assign in_i.ready = !q_status_i.full;
  assign push_o     = in_i.valid && !q_status_i.full;

  assign chan_ok  = (CH_W + 1)'(in_i.channel) < (CH_W + 1)'(CHANNELS);
  assign size_sel = size_i[in_i.channel];
  // capacities above the storage slice are taken as the slice size
  assign cap = (size_sel > SIZE_W'(MAX_DEPTH)) ? CAP_W'(MAX_DEPTH) : CAP_W'(size_sel);

  always_comb begin
    push_cmd_o.ch   = in_i.channel;
    push_cmd_o.data = in_i.data_in;
    push_cmd_o.cap  = cap;
    priority if (!chan_ok) begin
      push_cmd_o.op = OP_NOCHAN;
    end else if (mode_e'(in_i.mode) == MODE_CLEAR) begin
      push_cmd_o.op = OP_CLEAR;
    end else if (cap == '0) begin
      push_cmd_o.op = OP_REJECT;
    end else begin
      unique case (mode_e'(in_i.mode))
        MODE_WRITE: push_cmd_o.op = OP_WRITE;
        MODE_READ:  push_cmd_o.op = OP_READ;
        default:    push_cmd_o.op = OP_QUERY;
      endcase
    end
  end

endmodule

>>> hw/rtl/mcbrb_queue.sv
module mcbrb_queue
  import mcbrb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      push_cmd_i,
  input  logic      pop_i,
  output cmd_t      pop_cmd_o,
  output q_status_t status_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status_o.full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign status_o.empty = cnt_q == '0;
  assign pop_cmd_o      = entry_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? next_ptr(wptr_q) : wptr_q;
    rptr_d = pop_i ? next_ptr(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> hw/rtl/mcbrb_back.sv
module mcbrb_back
  import mcbrb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  q_status_t  q_status_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  mcbrb_out_if.source out_o
);

  logic [PTR_W-1:0]  rp_q [CHANNELS];
  logic [PTR_W-1:0]  wp_q [CHANNELS];
  logic              ef_q [CHANNELS];
  logic [DATA_W-1:0] mem [CHANNELS * MAX_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  logic              valid_q, valid_d;
  logic              status_q, status_d;
  logic [CAP_W-1:0]  free_q, free_d;
  logic              empty_q, empty_d;
  logic              rd_hit_q, rd_hit_d;

  logic [PTR_W-1:0]  rp_cur, wp_cur, rp_new, wp_new;
  logic              ef_cur, ef_new;
  logic              upd, mem_we, mem_re;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CAP_W-1:0] cap);
    logic [WIDE_W-1:0] n;
    n = WIDE_W'(p) + 1'b1;
    return (n >= WIDE_W'(cap)) ? '0 : n[PTR_W-1:0];
  endfunction

  // free space, limited to the capacity when pointers sit past a shrunk size
  function automatic logic [CAP_W-1:0] free_of(input logic ef, input logic [PTR_W-1:0] rd,
                                               input logic [PTR_W-1:0] wr,
                                               input logic [CAP_W-1:0] cap);
    logic [WIDE_W-1:0] sum;
    logic [WIDE_W-1:0] f;
    sum = WIDE_W'(rd) + WIDE_W'(cap);
    f   = '0;
    if (ef) begin
      f = WIDE_W'(cap);
    end else if (rd == wr) begin
      f = '0;
    end else if (rd < wr) begin
      f = (sum < WIDE_W'(wr)) ? '0 : sum - WIDE_W'(wr);
    end else begin
      f = WIDE_W'(rd) - WIDE_W'(wr);
    end
    return (f > WIDE_W'(cap)) ? cap : f[CAP_W-1:0];
  endfunction

  assign pop_o  = !q_status_i.empty && (!valid_q || out_o.ready);
  assign rp_cur = rp_q[cmd_i.ch];
  assign wp_cur = wp_q[cmd_i.ch];
  assign ef_cur = ef_q[cmd_i.ch];

  always_comb begin
    rp_new   = rp_cur;
    wp_new   = wp_cur;
    ef_new   = ef_cur;
    status_d = 1'b1;
    rd_hit_d = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    upd      = 1'b0;
    free_d   = '0;
    empty_d  = ef_cur;
    unique case (cmd_i.op)
      OP_WRITE: begin
        if (ef_cur || wp_cur != rp_cur) begin
          mem_we   = pop_o;
          wp_new   = advance(wp_cur, cmd_i.cap);
          ef_new   = 1'b0;
          status_d = 1'b0;
          upd      = pop_o;
        end
        free_d  = free_of(ef_new, rp_new, wp_new, cmd_i.cap);
        empty_d = ef_new;
      end
      OP_READ: begin
        if (!ef_cur) begin
          mem_re   = pop_o;
          rd_hit_d = 1'b1;
          rp_new   = advance(rp_cur, cmd_i.cap);
          ef_new   = rp_new == wp_cur;
          status_d = 1'b0;
          upd      = pop_o;
        end
        free_d  = free_of(ef_new, rp_new, wp_new, cmd_i.cap);
        empty_d = ef_new;
      end
      OP_QUERY: begin
        status_d = 1'b0;
        free_d   = free_of(ef_cur, rp_cur, wp_cur, cmd_i.cap);
      end
      OP_CLEAR: begin
        rp_new   = '0;
        wp_new   = '0;
        ef_new   = 1'b1;
        status_d = 1'b0;
        upd      = pop_o;
        free_d   = cmd_i.cap;
        empty_d  = 1'b1;
      end
      OP_REJECT: begin
        empty_d = ef_cur;
      end
      default: begin
        empty_d = 1'b1;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        rp_q[i] <= '0;
        wp_q[i] <= '0;
        ef_q[i] <= 1'b1;
      end
    end else begin
      valid_q <= valid_d;
      if (upd) begin
        rp_q[cmd_i.ch] <= rp_new;
        wp_q[cmd_i.ch] <= wp_new;
        ef_q[cmd_i.ch] <= ef_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= status_d;
      free_q   <= free_d;
      empty_q  <= empty_d;
      rd_hit_q <= rd_hit_d;
    end
  end

  // read data stays put until the next successful read, which needs a free slot
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[{cmd_i.ch, wp_cur}] <= cmd_i.data;
    end
    if (mem_re) begin
      rdata_q <= mem[{cmd_i.ch, rp_cur}];
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.status     = status_q;
  assign out_o.free_count = free_q;
  assign out_o.is_empty   = empty_q;
  assign out_o.data_out   = rd_hit_q ? rdata_q : '0;

endmodule

>>> hw/rtl/multi_channel_byte_ring_buffer.sv
// Four independent byte FIFOs sharing one 1024-byte store, each channel a 256-byte slice
// sized by its size register (zero leaves the channel unused, values above 256 act as 256).
// Every request (write, read, free-space query, clear) returns exactly one result
// transaction, in request order. A request is taken into a two-entry command queue
// and the execution stage retires one command per cycle unless the result slot is held,
// so the block sustains one transaction per cycle; that figure is set by the single
// pointer update per cycle in the execution stage. Each result is held in a register.
// The store needs no initialization: read a byte only after writing it. After changing
// a size register, clear that channel before use. Write size registers only when idle.
module multi_channel_byte_ring_buffer
  import mcbrb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [SIZE_W-1:0]    cfg_data_i,
  mcbrb_in_if.sink             in_i,
  mcbrb_out_if.source          out_o
);

  logic [SIZE_W-1:0] size_q [NUM_REGS];
  logic              push, pop;
  cmd_t              push_cmd, pop_cmd;
  q_status_t         q_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        size_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      size_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  mcbrb_front u_front (
    .in_i       (in_i),
    .size_i     (size_q),
    .q_status_i (q_status),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  mcbrb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .status_o   (q_status)
  );

  mcbrb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .cmd_i      (pop_cmd),
    .pop_o      (pop),
    .out_o      (out_o)
  );

  // a command is only retired into a free result slot
  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!out_o.valid || out_o.ready))
    else $error("command retired while result slot occupied");

  // an accepted request leaves the queue non-empty
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !q_status.empty)
    else $error("accepted request missing from queue");

  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty at once");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.free_count <= CAP_W'(MAX_DEPTH)))
    else $error("free count beyond slice size");

endmodule

>>> tb/sv/tb_top.sv
module tb_top
  import mcbrb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [REG_IDX_W-1:0] REG_SIZE_CH0 = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_CH1 = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_CH2 = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_CH3 = 2'd3;

  typedef struct packed {
    mode_e             mode;
    logic [CH_W-1:0]   ch;
    logic [DATA_W-1:0] data;
  } request_t;

  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] data_out;
    logic [CAP_W-1:0]  free_count;
    logic              is_empty;
  } answer_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_BURSTY
  } rx_pattern_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [SIZE_W-1:0]    cfg_data;

  mcbrb_in_if  in_if ();
  mcbrb_out_if out_if ();

  multi_channel_byte_ring_buffer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // shadow copy of the ring buffers
  logic [SIZE_W-1:0] size_regs [CHANNELS];
  logic [DATA_W-1:0] shadow_bytes [CHANNELS][MAX_DEPTH];
  bit                shadow_written [CHANNELS][MAX_DEPTH];
  int unsigned       rd_ptr [CHANNELS];
  int unsigned       wr_ptr [CHANNELS];
  bit                ch_empty [CHANNELS];

  answer_t     awaited_results [$];
  int          mismatches = 0;
  rx_pattern_e rx_pattern = RX_ALWAYS;
  int unsigned rx_cycle = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned capacity(int unsigned ch);
    return (size_regs[ch] > MAX_DEPTH) ? MAX_DEPTH : size_regs[ch];
  endfunction

  function automatic answer_t fifo_apply(request_t req);
    int unsigned ch, cap, rd, wr, f;
    answer_t ans;
    ch  = req.ch;
    cap = capacity(ch);
    ans = '{status: 1'b1, data_out: '0, free_count: '0, is_empty: 1'b1};
    if (req.mode == MODE_CLEAR) begin
      rd_ptr[ch]   = 0;
      wr_ptr[ch]   = 0;
      ch_empty[ch] = 1'b1;
      ans.status   = 1'b0;
    end else if (cap != 0) begin
      case (req.mode)
        MODE_WRITE: begin
          if (ch_empty[ch] || wr_ptr[ch] != rd_ptr[ch]) begin
            shadow_bytes[ch][wr_ptr[ch]]   = req.data;
            shadow_written[ch][wr_ptr[ch]] = 1'b1;
            wr_ptr[ch]   = (wr_ptr[ch] + 1 >= cap) ? 0 : wr_ptr[ch] + 1;
            ch_empty[ch] = 1'b0;
            ans.status   = 1'b0;
          end
        end
        MODE_READ: begin
          if (!ch_empty[ch]) begin
            ans.data_out = shadow_bytes[ch][rd_ptr[ch]];
            rd_ptr[ch]   = (rd_ptr[ch] + 1 >= cap) ? 0 : rd_ptr[ch] + 1;
            if (rd_ptr[ch] == wr_ptr[ch]) ch_empty[ch] = 1'b1;
            ans.status   = 1'b0;
          end
        end
        default: ans.status = 1'b0;
      endcase
    end
    if (cap != 0 || req.mode == MODE_CLEAR) begin
      rd = rd_ptr[ch];
      wr = wr_ptr[ch];
      if (ch_empty[ch]) f = cap;
      else if (rd == wr) f = 0;
      else if (rd < wr) f = (rd + cap < wr) ? 0 : rd + cap - wr;
      else f = rd - wr;
      if (f > cap) f = cap;
      ans.free_count = CAP_W'(f);
    end
    ans.is_empty = ch_empty[ch];
    return ans;
  endfunction

  // valid stays high after a transaction so back-to-back sends form a burst
  task automatic send_request(input mode_e mode, input int unsigned ch,
                              input logic [DATA_W-1:0] data);
    request_t req;
    req.mode = mode;
    req.ch   = CH_W'(ch);
    req.data = data;
    // never read a store entry that was not written
    if (req.mode == MODE_READ && capacity(ch) != 0 && !ch_empty[ch] &&
        !shadow_written[ch][rd_ptr[ch]]) begin
      req.mode = MODE_QUERY;
    end
    @(negedge clk_i);
    in_if.valid   = 1'b1;
    in_if.mode    = req.mode;
    in_if.channel = req.ch;
    in_if.data_in = req.data;
    do @(posedge clk_i); while (!in_if.ready);
    awaited_results.push_back(fifo_apply(req));
  endtask

  task automatic pause_sender(input int unsigned gap);
    @(negedge clk_i);
    in_if.valid = 1'b0;
    repeat (gap) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    pause_sender(0);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [REG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    @(negedge clk_i);
    cfg_we   = 1'b0;
    size_regs[idx] = value;
  endtask

  task automatic test_unused_channels();
    send_request(MODE_WRITE, 0, 8'hFF);
    send_request(MODE_READ, 1, 8'h00);
    send_request(MODE_QUERY, 2, 8'h55);
    send_request(MODE_CLEAR, 3, 8'hAA);
  endtask

  task automatic test_fill_and_drain();
    wait_drained();
    write_size(REG_SIZE_CH0, 9'd1);
    write_size(REG_SIZE_CH1, 9'd2);
    write_size(REG_SIZE_CH2, 9'd256);
    write_size(REG_SIZE_CH3, 9'd511);
    send_request(MODE_WRITE, 0, 8'h00);
    send_request(MODE_WRITE, 0, 8'hFF);   // full
    send_request(MODE_READ, 0, 8'h00);
    send_request(MODE_READ, 0, 8'h00);    // empty
    send_request(MODE_WRITE, 3, 8'hA5);   // oversized capacity acts as MAX_DEPTH
    send_request(MODE_QUERY, 3, 8'h00);
    send_request(MODE_READ, 3, 8'h00);
    send_request(MODE_WRITE, 1, 8'hFF);
    send_request(MODE_WRITE, 1, 8'h5A);
    send_request(MODE_WRITE, 1, 8'h01);   // full
    send_request(MODE_READ, 1, 8'h00);
    send_request(MODE_CLEAR, 1, 8'h00);
  endtask

  task automatic test_resize_without_clear();
    send_request(MODE_WRITE, 2, 8'h80);
    send_request(MODE_WRITE, 2, 8'h7F);
    send_request(MODE_WRITE, 2, 8'h01);
    send_request(MODE_READ, 2, 8'h00);
    wait_drained();
    // the write pointer now sits beyond the new capacity
    write_size(REG_SIZE_CH2, 9'd2);
    write_size(REG_SIZE_CH1, 9'd0);
    send_request(MODE_WRITE, 2, 8'hC3);
    send_request(MODE_QUERY, 2, 8'h00);
    send_request(MODE_READ, 2, 8'h00);
    send_request(MODE_READ, 2, 8'h00);
    send_request(MODE_WRITE, 1, 8'h3C);
    send_request(MODE_CLEAR, 1, 8'h00);
  endtask

  task automatic test_reconfigure();
    int unsigned pick;
    logic [SIZE_W-1:0] sz;
    wait_drained();
    for (int ch = 0; ch < CHANNELS; ch++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: sz = 9'd0;
        1: sz = 9'd1;
        2: sz = 9'd2;
        3: sz = 9'd256;
        4: sz = SIZE_W'($urandom_range(257, 511));
        5: sz = 9'd511;
        default: sz = SIZE_W'($urandom_range(3, 12));
      endcase
      write_size(REG_IDX_W'(ch), sz);
    end
    // most channels get the clear that a size change calls for
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if ($urandom_range(0, 3) != 0) begin
        send_request(MODE_CLEAR, ch, DATA_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned sent, burst, gap, write_pct, r;
    mode_e m;
    sent = 0;
    write_pct = $urandom_range(20, 80);
    while (sent < count) begin
      burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3) m = MODE_CLEAR;
        else if (r < 8) m = MODE_QUERY;
        else if (r < 8 + (92 * write_pct) / 100) m = MODE_WRITE;
        else m = MODE_READ;
        send_request(m, $urandom_range(0, CHANNELS - 1), DATA_W'($urandom_range(0, 255)));
        sent++;
      end
      gap = $urandom_range(0, 4);
      if (gap != 0) pause_sender(gap);
    end
  endtask

  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_pattern = rx_pattern_e'($urandom_range(0, 3));
    case (rx_pattern)
      RX_ALWAYS: out_if.ready = 1'b1;
      RX_COIN:   out_if.ready = 1'($urandom_range(0, 1));
      RX_SPARSE: out_if.ready = (rx_cycle % 4 == 0);
      default:   out_if.ready = ((rx_cycle / 8) % 2 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (awaited_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected result transaction at %0t", $realtime);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_if.status !== want.status || out_if.data_out !== want.data_out ||
            out_if.free_count !== want.free_count || out_if.is_empty !== want.is_empty) begin
          if (mismatches < 10) begin
            $display("mismatch at %0t: expected status=%0d data=%02h free=%0d empty=%0d",
                     $realtime, want.status, want.data_out, want.free_count, want.is_empty);
            $display("                 actual   status=%0d data=%02h free=%0d empty=%0d",
                     out_if.status, out_if.data_out, out_if.free_count, out_if.is_empty);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.mode    = MODE_WRITE;
    in_if.channel = '0;
    in_if.data_in = '0;
    out_if.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    rst_ni        = 1'b0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      size_regs[ch] = '0;
      rd_ptr[ch]    = 0;
      wr_ptr[ch]    = 0;
      ch_empty[ch]  = 1'b1;
      for (int a = 0; a < MAX_DEPTH; a++) shadow_written[ch][a] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_unused_channels();
    test_fill_and_drain();
    test_resize_without_clear();
    for (int p = 0; p < 7; p++) begin
      test_reconfigure();
      test_random_traffic(145);
    end

    pause_sender(0);
    for (int i = 0; i < 20000 && awaited_results.size() != 0; i++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/mcbrb_pkg.sv
hw/rtl/mcbrb_if.sv
hw/rtl/mcbrb_front.sv
hw/rtl/mcbrb_queue.sv
hw/rtl/mcbrb_back.sv
hw/rtl/multi_channel_byte_ring_buffer.sv
tb/sv/tb_top.sv
